// File: hdl/mphm_pkg.sv
// Shared types and constants of the multichannel peak hold meter.
// No dependencies; the interfaces and the top level use it by scoped names.
package mphm_pkg;

    localparam int CHANNEL_BITS   = 4;
    localparam int PEAK_BITS      = 16;
    localparam int FACTOR_BITS    = 16;
    localparam int COUNT_BITS     = 5;
    localparam int AGE_BITS       = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [AGE_BITS-1:0]    AGE_MAX             = 4'd15;
    localparam logic [COUNT_BITS-1:0]  RST_CHANNEL_COUNT   = 5'd2;
    localparam logic [FACTOR_BITS-1:0] RST_DISPLAY_DECAY   = 16'd55706;
    localparam logic [FACTOR_BITS-1:0] RST_HOLD_DECAY      = 16'd60293;
    localparam logic [AGE_BITS-1:0]    RST_HOLD_STEPS      = 4'd8;

    typedef enum logic [1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_DISPLAY_DECAY = 2'd1,
        CFG_HOLD_DECAY    = 2'd2,
        CFG_HOLD_STEPS    = 2'd3
    } t_cfg_index;

endpackage

// File: hdl/mphm_if.sv
// Valid/ready channel interfaces of the peak hold meter: samples, results, configuration.
// Depends on mphm_pkg for field widths and the register index type.
interface mphm_in_if;
    logic                                valid;
    logic                                ready;
    logic [mphm_pkg::CHANNEL_BITS-1:0]   channel;
    logic [mphm_pkg::PEAK_BITS-1:0]      peak;

    modport source (output valid, output channel, output peak, input ready);
    modport sink   (input valid, input channel, input peak, output ready);
endinterface

interface mphm_out_if;
    logic                                valid;
    logic                                ready;
    logic [mphm_pkg::CHANNEL_BITS-1:0]   out_channel;
    logic [mphm_pkg::PEAK_BITS-1:0]      display_level;
    logic [mphm_pkg::PEAK_BITS-1:0]      held_level;
    logic                                bad_channel;

    modport source (output valid, output out_channel, output display_level,
                    output held_level, output bad_channel, input ready);
    modport sink   (input valid, input out_channel, input display_level,
                    input held_level, input bad_channel, output ready);
endinterface

interface mphm_cfg_if;
    logic                                valid;
    logic                                ready;
    mphm_pkg::t_cfg_index                index;
    logic [mphm_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/multichannel_peak_hold_meter.sv
// Top level of the multichannel peak hold meter with per-channel state in one memory.
// Depends on mphm_pkg and the channel interfaces in mphm_if.sv.
//
// Usage:
// Each transaction on i_in carries a channel index and a linear peak sample in
// unsigned Q1.15. For every transaction exactly one result leaves on o_out, in
// order: the channel, its new display level, its new held peak, and a flag for
// a channel at or above the channel count, which changes no state and reports
// zero levels.
// The state of all channels lives in one memory with a registered read. An
// item reads its entry when it is accepted, is updated in the update stage and
// written back as it advances; a write to the same entry in the accept cycle is forwarded.
// An item passes the update stage, then the result register. One item is
// accepted per cycle while results are taken, set by the single read-modify-write pass.
// When the receiver stalls, the result register holds and one more item waits
// in the update stage; i_in.ready then falls until the result is taken.
// Reset loads the register defaults and marks every entry empty, so it reads as
// zero with no clearing pass. A write of the channel count also marks every entry empty.
// i_cfg is always ready; the user must write it only while the meter is idle; the block does not enforce it.
module multichannel_peak_hold_meter #(
    parameter int MAX_CHANNELS = 16,
    parameter int LEVEL_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mphm_in_if.sink    i_in,
    mphm_cfg_if.sink   i_cfg,
    mphm_out_if.source o_out
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LB = LEVEL_BITS;
    localparam int FB = mphm_pkg::FACTOR_BITS;
    localparam int GB = mphm_pkg::AGE_BITS;
    localparam int MW = 2 * LB + GB;
    localparam int PW = LB + FB;

    logic [MW-1:0]                       r_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]             r_entry_vld;
    logic [MW-1:0]                       r_rd_data;

    logic [mphm_pkg::COUNT_BITS-1:0]     r_count;
    logic [mphm_pkg::COUNT_BITS-1:0]     n_count;
    logic [FB-1:0]                       r_disp_decay;
    logic [FB-1:0]                       r_hold_decay;
    logic [GB-1:0]                       r_hold_steps;

    logic                                r_s1_vld;
    logic [mphm_pkg::CHANNEL_BITS-1:0]   r_s1_ch;
    logic [LB-1:0]                       r_s1_peak;
    logic                                r_s1_fwd;
    logic [MW-1:0]                       r_s1_fwd_data;

    logic                                r_out_vld;
    logic [mphm_pkg::CHANNEL_BITS-1:0]   r_out_ch;
    logic [mphm_pkg::PEAK_BITS-1:0]      r_out_disp;
    logic [mphm_pkg::PEAK_BITS-1:0]      r_out_hold;
    logic                                r_out_bad;

    logic                                in_acc;
    logic                                cfg_acc;
    logic [AW-1:0]                       in_addr;
    logic [AW-1:0]                       s1_addr;
    logic                                s1_bad;
    logic                                s1_adv;
    logic                                wr_en;
    logic [MW-1:0]                       wr_data;
    logic [MW-1:0]                       cur;
    logic [LB-1:0]                       cur_disp;
    logic [LB-1:0]                       cur_hold;
    logic [GB-1:0]                       cur_age;
    logic [PW-1:0]                       prod_disp;
    logic [PW-1:0]                       prod_hold;
    logic [LB-1:0]                       scaled_disp;
    logic [LB-1:0]                       scaled_hold;
    logic [LB-1:0]                       new_disp;
    logic [LB-1:0]                       new_hold;
    logic [GB-1:0]                       new_age;
    logic [GB-1:0]                       inc_age;

    assign in_acc  = i_in.valid && i_in.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign in_addr = AW'(i_in.channel);
    assign s1_addr = AW'(r_s1_ch);

    assign s1_bad = ({1'b0, r_s1_ch} >= r_count) || (int'(r_s1_ch) >= MAX_CHANNELS);
    assign s1_adv = r_s1_vld && (!r_out_vld || o_out.ready);
    assign wr_en  = s1_adv && !s1_bad;

    assign i_in.ready  = !r_s1_vld || s1_adv;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (i_cfg.data[mphm_pkg::COUNT_BITS-1:0] == '0) begin
            n_count = mphm_pkg::COUNT_BITS'(1);
        end else if (int'(i_cfg.data[mphm_pkg::COUNT_BITS-1:0]) > MAX_CHANNELS) begin
            n_count = mphm_pkg::COUNT_BITS'(MAX_CHANNELS);
        end else begin
            n_count = i_cfg.data[mphm_pkg::COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= mphm_pkg::RST_CHANNEL_COUNT;
            r_disp_decay <= mphm_pkg::RST_DISPLAY_DECAY;
            r_hold_decay <= mphm_pkg::RST_HOLD_DECAY;
            r_hold_steps <= mphm_pkg::RST_HOLD_STEPS;
            r_entry_vld  <= '0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg.index)
                    mphm_pkg::CFG_CHANNEL_COUNT: begin
                        r_count <= n_count;
                    end
                    mphm_pkg::CFG_DISPLAY_DECAY: begin
                        r_disp_decay <= i_cfg.data[FB-1:0];
                    end
                    mphm_pkg::CFG_HOLD_DECAY: begin
                        r_hold_decay <= i_cfg.data[FB-1:0];
                    end
                    mphm_pkg::CFG_HOLD_STEPS: begin
                        r_hold_steps <= i_cfg.data[GB-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_acc && i_cfg.index == mphm_pkg::CFG_CHANNEL_COUNT) begin
                r_entry_vld <= '0;
            end else if (wr_en) begin
                r_entry_vld[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[s1_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= r_mem[in_addr];
        end
    end

    // The memory read misses a write-back at the same edge; that data is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ch       <= i_in.channel;
            r_s1_peak     <= LB'(i_in.peak);
            r_s1_fwd      <= wr_en && (s1_addr == in_addr);
            r_s1_fwd_data <= wr_data;
        end
    end

    always_comb begin
        if (r_s1_fwd) begin
            cur = r_s1_fwd_data;
        end else if (r_entry_vld[s1_addr]) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
    end

    assign cur_disp = cur[MW-1 -: LB];
    assign cur_hold = cur[GB +: LB];
    assign cur_age  = cur[GB-1:0];

    assign prod_disp   = PW'(cur_disp) * PW'(r_disp_decay);
    assign prod_hold   = PW'(cur_hold) * PW'(r_hold_decay);
    assign scaled_disp = prod_disp[PW-1:FB];
    assign scaled_hold = prod_hold[PW-1:FB];
    assign inc_age     = (cur_age < mphm_pkg::AGE_MAX) ? cur_age + 1'b1 : cur_age;

    always_comb begin
        if (cur_disp < r_s1_peak) begin
            new_disp = r_s1_peak;
        end else if (r_s1_peak > scaled_disp) begin
            new_disp = r_s1_peak;
        end else begin
            new_disp = scaled_disp;
        end

        new_hold = cur_hold;
        new_age  = inc_age;
        if (r_s1_peak >= cur_hold) begin
            new_hold = r_s1_peak;
            new_age  = '0;
        end else if (inc_age > r_hold_steps) begin
            new_hold = (new_disp > scaled_hold) ? new_disp : scaled_hold;
        end
    end

    assign wr_data = {new_disp, new_hold, new_age};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_ch   <= r_s1_ch;
            r_out_bad  <= s1_bad;
            r_out_disp <= s1_bad ? '0 : mphm_pkg::PEAK_BITS'(new_disp);
            r_out_hold <= s1_bad ? '0 : mphm_pkg::PEAK_BITS'(new_hold);
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.out_channel   = r_out_ch;
    assign o_out.display_level = r_out_disp;
    assign o_out.held_level    = r_out_hold;
    assign o_out.bad_channel   = r_out_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.bad_channel |-> o_out.display_level == '0 &&
            o_out.held_level == '0)
        else $error("flagged result carries nonzero levels");

    a_hold_above_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.bad_channel |-> o_out.held_level >= o_out.display_level)
        else $error("held peak below display level");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted transaction lost before update stage");

    a_no_write_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !s1_bad && r_s1_vld)
        else $error("state written for a flagged channel");

endmodule
